### rtl/core/assert_macros.svh
// Assertion shorthands used by the property checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SEFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen.
`define SEFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `SEFR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/core/sefr_pkg.sv
package sefr_pkg;

  localparam int unsigned POS_W   = 6;   // payload index, up to 63
  localparam int unsigned LEN_W   = 7;   // readout length, up to 127
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned NUM_CNT = 4;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'h55;

  // event counter slots
  localparam logic [1:0] CNT_OK       = 2'd0;
  localparam logic [1:0] CNT_CRC_FAIL = 2'd1;
  localparam logic [1:0] CNT_FMT_FAIL = 2'd2;
  localparam logic [1:0] CNT_RESYNC   = 2'd3;

  typedef enum logic [0:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_WAIT      = 3'd0,
    ST_BUSY      = 3'd1,
    ST_OK        = 3'd2,
    ST_CRC_FAIL  = 3'd3,
    ST_PROTO_ERR = 3'd4
  } status_e;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_vec_t;

  // front -> back command, one per accepted byte
  typedef struct packed {
    status_e            status;
    logic [15:0]        pkt_id;
    logic [7:0]         seq_num;
    logic [3:0]         payload_len;
    logic [LEN_W-1:0]   rd_len;
    logic               wr_en;
    logic [POS_W-1:0]   wr_pos;
    logic [7:0]         wr_data;
    cnt_vec_t           cnt;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] pkt_id;
    logic [7:0]  seq_num;
    logic [3:0]  payload_len;
    logic [7:0]  data_byte;
    logic [2:0]  byte_pos;
    logic        last;
    cnt_vec_t    cnt;
  } res_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/sefr_front.sv
module sefr_front #(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_addr_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 cmd_valid_o,
  output sefr_pkg::cmd_t       cmd_o
);

  localparam int unsigned FPW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_WAIT, PH_ID, PH_SEQ, PH_LEN, PH_PAY, PH_CRC, PH_END
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [FPW-1:0]     field_pos_q, field_pos_d, fp_inc;
  logic [15:0]        id_q, id_d;
  logic [7:0]         seq_q, seq_d;
  logic [7:0]         len_q, len_d;
  logic [15:0]        rx_crc_q, rx_crc_d;
  logic [15:0]        run_crc_q, run_crc_d, crc_nxt;
  sefr_pkg::cnt_vec_t cnt_q, cnt_d;
  logic [7:0]         start_q, end_q;
  sefr_pkg::status_e  status;
  logic               wr_en;

  assign crc_nxt = sefr_pkg::crc_byte(run_crc_q, rx_byte_i);
  assign fp_inc  = field_pos_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    field_pos_d = field_pos_q;
    id_d        = id_q;
    seq_d       = seq_q;
    len_d       = len_q;
    rx_crc_d    = rx_crc_q;
    run_crc_d   = run_crc_q;
    cnt_d       = cnt_q;
    status      = sefr_pkg::ST_BUSY;
    wr_en       = 1'b0;
    unique case (phase_q)
      PH_WAIT: begin
        if (rx_byte_i == start_q) begin
          phase_d     = PH_ID;
          field_pos_d = '0;
          run_crc_d   = sefr_pkg::CRC_INIT;
        end else begin
          status = sefr_pkg::ST_WAIT;
        end
      end
      PH_ID: begin
        run_crc_d = crc_nxt;
        if (field_pos_q == '0) begin
          id_d        = {rx_byte_i, 8'h00};
          field_pos_d = FPW'(1);
        end else begin
          id_d        = {id_q[15:8], rx_byte_i};
          field_pos_d = '0;
          phase_d     = PH_SEQ;
        end
      end
      PH_SEQ: begin
        run_crc_d = crc_nxt;
        seq_d     = rx_byte_i;
        phase_d   = PH_LEN;
      end
      PH_LEN: begin
        run_crc_d   = crc_nxt;
        len_d       = rx_byte_i;
        field_pos_d = '0;
        if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
          status = sefr_pkg::ST_PROTO_ERR;
          cnt_d[sefr_pkg::CNT_FMT_FAIL] = cnt_q[sefr_pkg::CNT_FMT_FAIL] + 1'b1;
          cnt_d[sefr_pkg::CNT_RESYNC]   = cnt_q[sefr_pkg::CNT_RESYNC] + 1'b1;
          phase_d = PH_WAIT;
        end else if (rx_byte_i == 8'h00) begin
          phase_d = PH_CRC;
        end else begin
          phase_d = PH_PAY;
        end
      end
      PH_PAY: begin
        run_crc_d   = crc_nxt;
        wr_en       = 1'b1;
        field_pos_d = fp_inc;
        if (8'(fp_inc) >= len_q) begin
          field_pos_d = '0;
          phase_d     = PH_CRC;
        end
      end
      PH_CRC: begin
        if (field_pos_q == '0) begin
          rx_crc_d    = {rx_byte_i, 8'h00};
          field_pos_d = FPW'(1);
        end else begin
          rx_crc_d    = {rx_crc_q[15:8], rx_byte_i};
          field_pos_d = '0;
          phase_d     = PH_END;
        end
      end
      PH_END: begin
        phase_d     = PH_WAIT;
        field_pos_d = '0;
        if (rx_byte_i == end_q) begin
          if (run_crc_q == rx_crc_q) begin
            status = sefr_pkg::ST_OK;
            cnt_d[sefr_pkg::CNT_OK] = cnt_q[sefr_pkg::CNT_OK] + 1'b1;
          end else begin
            status = sefr_pkg::ST_CRC_FAIL;
            cnt_d[sefr_pkg::CNT_CRC_FAIL] = cnt_q[sefr_pkg::CNT_CRC_FAIL] + 1'b1;
            cnt_d[sefr_pkg::CNT_RESYNC]   = cnt_q[sefr_pkg::CNT_RESYNC] + 1'b1;
          end
        end else begin
          status = sefr_pkg::ST_PROTO_ERR;
          cnt_d[sefr_pkg::CNT_FMT_FAIL] = cnt_q[sefr_pkg::CNT_FMT_FAIL] + 1'b1;
          cnt_d[sefr_pkg::CNT_RESYNC]   = cnt_q[sefr_pkg::CNT_RESYNC] + 1'b1;
        end
      end
      default: begin
        phase_d     = PH_WAIT;
        field_pos_d = '0;
        status      = sefr_pkg::ST_WAIT;
      end
    endcase
  end

  always_comb begin
    cmd_o.status      = status;
    cmd_o.pkt_id      = id_d;
    cmd_o.seq_num     = seq_d;
    cmd_o.payload_len = (len_d > 8'd15) ? 4'd15 : len_d[3:0];
    cmd_o.rd_len      = sefr_pkg::LEN_W'(len_d);
    cmd_o.wr_en       = wr_en;
    cmd_o.wr_pos      = sefr_pkg::POS_W'(field_pos_q);
    cmd_o.wr_data     = rx_byte_i;
    cmd_o.cnt         = cnt_d;
  end

  assign cmd_valid_o = in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      field_pos_q <= '0;
      id_q        <= '0;
      seq_q       <= '0;
      len_q       <= '0;
      rx_crc_q    <= '0;
      run_crc_q   <= sefr_pkg::CRC_INIT;
      cnt_q       <= '0;
      start_q     <= sefr_pkg::START_MARKER_RST;
      end_q       <= sefr_pkg::END_MARKER_RST;
    end else begin
      if (in_valid_i) begin
        phase_q     <= phase_d;
        field_pos_q <= field_pos_d;
        id_q        <= id_d;
        seq_q       <= seq_d;
        len_q       <= len_d;
        rx_crc_q    <= rx_crc_d;
        run_crc_q   <= run_crc_d;
        cnt_q       <= cnt_d;
      end
      if (cfg_we_i) begin
        unique case (sefr_pkg::reg_idx_e'(cfg_addr_i))
          sefr_pkg::REG_START_MARKER: start_q <= cfg_wdata_i;
          sefr_pkg::REG_END_MARKER:   end_q   <= cfg_wdata_i;
          default:                    start_q <= start_q;
        endcase
      end
    end
  end

endmodule

### rtl/core/sefr_cmd_fifo.sv
module sefr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sefr_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output sefr_pkg::cmd_t data_o,
  output logic           empty_o
);

  sefr_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

### rtl/core/sefr_back.sv
module sefr_back #(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sefr_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  output sefr_pkg::res_t res_o,
  input  logic           pop_i
);

  localparam int unsigned PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [1:0] {BK_IDLE, BK_FETCH, BK_EMIT} bk_state_e;

  bk_state_e                     state_q;
  sefr_pkg::cmd_t                cur_q;
  logic [sefr_pkg::LEN_W-1:0]    idx_q, idx_inc;
  logic [7:0]                    store_q [MAX_PAYLOAD];
  logic [7:0]                    rd_data_q;
  logic                          out_valid_q;
  sefr_pkg::res_t                res_q;
  logic                          slot_free, burst, res_load;

  assign slot_free   = !out_valid_q || pop_i;
  assign cmd_pop_o   = (state_q == BK_IDLE) && cmd_valid_i && slot_free;
  assign burst       = (cmd_i.status == sefr_pkg::ST_OK) && (cmd_i.rd_len != '0);
  assign res_load    = (cmd_pop_o && !burst) || ((state_q == BK_EMIT) && slot_free);
  assign idx_inc     = idx_q + 1'b1;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // payload store: byte writes in command order, registered readout
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.wr_en) begin
      store_q[cmd_i.wr_pos[PW-1:0]] <= cmd_i.wr_data;
    end
    if (state_q == BK_FETCH) begin
      rd_data_q <= store_q[idx_q[PW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cur_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BK_IDLE: begin
          if (cmd_pop_o) begin
            if (burst) begin
              cur_q   <= cmd_i;
              idx_q   <= '0;
              state_q <= BK_FETCH;
            end else begin
              res_q.status      <= cmd_i.status;
              res_q.pkt_id      <= cmd_i.pkt_id;
              res_q.seq_num     <= cmd_i.seq_num;
              res_q.payload_len <= cmd_i.payload_len;
              res_q.data_byte   <= 8'h00;
              res_q.byte_pos    <= 3'd0;
              res_q.last        <= 1'b1;
              res_q.cnt         <= cmd_i.cnt;
            end
          end
        end
        BK_FETCH: begin
          state_q <= BK_EMIT;
        end
        BK_EMIT: begin
          if (slot_free) begin
            res_q.status      <= cur_q.status;
            res_q.pkt_id      <= cur_q.pkt_id;
            res_q.seq_num     <= cur_q.seq_num;
            res_q.payload_len <= cur_q.payload_len;
            res_q.data_byte   <= rd_data_q;
            res_q.byte_pos    <= idx_q[2:0];
            res_q.last        <= (idx_inc == cur_q.rd_len);
            res_q.cnt         <= cur_q.cnt;
            if (idx_inc == cur_q.rd_len) begin
              state_q <= BK_IDLE;
            end else begin
              idx_q   <= idx_inc;
              state_q <= BK_FETCH;
            end
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/sof_eof_frame_receiver_crc16.sv
// A byte's result goes through the two-entry command queue, which absorbs bursts,
// then the result register. One byte per cycle goes in while the queue has room.
// A good frame of n payload bytes reads them out of the store one by one, each byte
// through a fetch state, then an emit state; the store has a single read port.
// Reset (rst_ni low, async) clears the parser, CRC, counters and queues and restores
// the start/end markers to 0xAA/0x55; the payload store is not cleared.
module sof_eof_frame_receiver_crc16 #(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // byte input side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [15:0] pkt_id_o,
  output logic [7:0]  seq_num_o,
  output logic [3:0]  payload_len_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  byte_pos_o,
  output logic        last_o,
  output logic [31:0] ok_count_o,
  output logic [31:0] crc_fail_count_o,
  output logic [31:0] format_fail_count_o,
  output logic [31:0] realign_count_o
);

  // Front: frame parser, CRC, counters. Each transfer makes one command.
  // Back: turns commands into results; a good frame becomes a payload burst.
  sefr_pkg::cmd_t front_cmd, back_cmd;
  sefr_pkg::res_t res;
  logic           in_xfer, front_valid, q_full, q_empty, q_pop, out_valid;

  assign in_xfer = push && !q_full;
  assign full    = q_full;

  sefr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_xfer),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  // short queue between parser and readout so each side stalls on its own
  sefr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (back_cmd),
    .empty_o (q_empty)
  );

  sefr_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .res_o       (res),
    .pop_i       (pop && out_valid)
  );

  // result register sits in the back; empty is the inverse of its valid bit
  assign empty               = !out_valid;
  assign status_o            = res.status;
  assign pkt_id_o            = res.pkt_id;
  assign seq_num_o           = res.seq_num;
  assign payload_len_o       = res.payload_len;
  assign data_byte_o         = res.data_byte;
  assign byte_pos_o          = res.byte_pos;
  assign last_o              = res.last;
  assign ok_count_o          = res.cnt[sefr_pkg::CNT_OK];
  assign crc_fail_count_o    = res.cnt[sefr_pkg::CNT_CRC_FAIL];
  assign format_fail_count_o = res.cnt[sefr_pkg::CNT_FMT_FAIL];
  assign realign_count_o     = res.cnt[sefr_pkg::CNT_RESYNC];

endmodule

### rtl/core/sefr_checker.sv
`include "assert_macros.svh"

module sefr_prop_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status_o,
  input logic [3:0]  payload_len_o,
  input logic [7:0]  data_byte_o,
  input logic [2:0]  byte_pos_o,
  input logic        last_o,
  input logic [31:0] ok_count_o
);

  logic        stall, bad_status, dirty_non_ok, burst_on_empty;
  logic [42:0] res_v;

  assign stall      = !empty && !pop;
  assign res_v      = {status_o, data_byte_o, ok_count_o};
  assign bad_status = !empty && status_o > 3'd4;
  assign dirty_non_ok = !empty && status_o != sefr_pkg::ST_OK &&
                        (!last_o || data_byte_o != 8'd0 || byte_pos_o != 3'd0);
  assign burst_on_empty = !empty && status_o == sefr_pkg::ST_OK && payload_len_o == 4'd0 &&
                          (!last_o || byte_pos_o != 3'd0);

  // a waiting result must not change under a stall
  `SEFR_ASSERT(a_hold, clk_i, rst_ni, stall |=> !empty && $stable(res_v), "held result changed")

  `SEFR_ASSERT_NEVER(a_status_range, clk_i, rst_ni, bad_status, "status code out of range")

  // only good frames carry payload; everything else is a single clean result
  `SEFR_ASSERT_NEVER(a_non_ok_clean, clk_i, rst_ni, dirty_non_ok, "non-ok result carries payload")

  `SEFR_ASSERT_NEVER(a_empty_frame, clk_i, rst_ni, burst_on_empty, "empty good frame gave a burst")

endmodule

bind sof_eof_frame_receiver_crc16 sefr_prop_checker u_sefr_prop_checker (.*);

### dv/sefr_tb_pkg.sv
package sefr_tb_pkg;

  // CRC-16/CCITT-FALSE, one byte, MSB first, no reflection
  function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & sefr_pkg::CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ sefr_pkg::CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### dv/sefr_checker.sv
module sefr_checker #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] pkt_id_i,
  input  logic [7:0]  seq_num_i,
  input  logic [3:0]  payload_len_i,
  input  logic [7:0]  data_byte_i,
  input  logic [2:0]  byte_pos_i,
  input  logic        last_i,
  input  logic [31:0] ok_count_i,
  input  logic [31:0] crc_fail_count_i,
  input  logic [31:0] format_fail_count_i,
  input  logic [31:0] realign_count_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PRS_WAIT, PRS_ID, PRS_SEQ, PRS_LEN, PRS_PAY, PRS_CRC, PRS_EOF
  } parse_e;

  parse_e             prs;
  int unsigned        fpos;
  logic [15:0]        id_q;
  logic [7:0]         seq_q;
  logic [7:0]         len_q;
  logic [15:0]        rx_crc_q;
  logic [15:0]        run_crc_q;
  logic [7:0]         pay_mem [MAX_LEN];
  sefr_pkg::cnt_vec_t evt_cnt;
  logic [7:0]         start_mark;
  logic [7:0]         end_mark;

  sefr_pkg::res_t     due_results[$];
  int unsigned        fails = 0;

  task automatic queue_result(input sefr_pkg::status_e st, input logic [7:0] d,
                              input logic [2:0] p, input logic l);
    sefr_pkg::res_t r;
    r.status      = st;
    r.pkt_id      = id_q;
    r.seq_num     = seq_q;
    r.payload_len = (len_q > 8'd15) ? 4'hF : len_q[3:0];
    r.data_byte   = d;
    r.byte_pos    = p;
    r.last        = l;
    r.cnt         = evt_cnt;
    due_results.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    sefr_pkg::status_e st;
    st = sefr_pkg::ST_BUSY;
    case (prs)
      PRS_WAIT: begin
        if (b == start_mark) begin
          prs       = PRS_ID;
          fpos      = 0;
          run_crc_q = sefr_pkg::CRC_INIT;
        end else begin
          st = sefr_pkg::ST_WAIT;
        end
      end
      PRS_ID: begin
        run_crc_q = sefr_tb_pkg::crc16_ccitt_step(run_crc_q, b);
        if (fpos == 0) begin
          id_q = {b, 8'h00};
          fpos = 1;
        end else begin
          id_q = {id_q[15:8], b};
          fpos = 0;
          prs  = PRS_SEQ;
        end
      end
      PRS_SEQ: begin
        run_crc_q = sefr_tb_pkg::crc16_ccitt_step(run_crc_q, b);
        seq_q     = b;
        prs       = PRS_LEN;
      end
      PRS_LEN: begin
        run_crc_q = sefr_tb_pkg::crc16_ccitt_step(run_crc_q, b);
        len_q     = b;
        fpos      = 0;
        if (b > MAX_LEN) begin
          st = sefr_pkg::ST_PROTO_ERR;
          evt_cnt[sefr_pkg::CNT_FMT_FAIL] = evt_cnt[sefr_pkg::CNT_FMT_FAIL] + 1;
          evt_cnt[sefr_pkg::CNT_RESYNC]   = evt_cnt[sefr_pkg::CNT_RESYNC] + 1;
          prs = PRS_WAIT;
        end else begin
          prs = (b == 8'd0) ? PRS_CRC : PRS_PAY;
        end
      end
      PRS_PAY: begin
        run_crc_q = sefr_tb_pkg::crc16_ccitt_step(run_crc_q, b);
        if (fpos < MAX_LEN) pay_mem[fpos] = b;
        fpos++;
        if (fpos >= len_q) begin
          fpos = 0;
          prs  = PRS_CRC;
        end
      end
      PRS_CRC: begin
        if (fpos == 0) begin
          rx_crc_q = {b, 8'h00};
          fpos     = 1;
        end else begin
          rx_crc_q = {rx_crc_q[15:8], b};
          fpos     = 0;
          prs      = PRS_EOF;
        end
      end
      PRS_EOF: begin
        prs  = PRS_WAIT;
        fpos = 0;
        if (b == end_mark) begin
          if (run_crc_q == rx_crc_q) begin
            st = sefr_pkg::ST_OK;
            evt_cnt[sefr_pkg::CNT_OK] = evt_cnt[sefr_pkg::CNT_OK] + 1;
          end else begin
            st = sefr_pkg::ST_CRC_FAIL;
            evt_cnt[sefr_pkg::CNT_CRC_FAIL] = evt_cnt[sefr_pkg::CNT_CRC_FAIL] + 1;
            evt_cnt[sefr_pkg::CNT_RESYNC]   = evt_cnt[sefr_pkg::CNT_RESYNC] + 1;
          end
        end else begin
          st = sefr_pkg::ST_PROTO_ERR;
          evt_cnt[sefr_pkg::CNT_FMT_FAIL] = evt_cnt[sefr_pkg::CNT_FMT_FAIL] + 1;
          evt_cnt[sefr_pkg::CNT_RESYNC]   = evt_cnt[sefr_pkg::CNT_RESYNC] + 1;
        end
      end
      default: begin
        prs  = PRS_WAIT;
        fpos = 0;
        st   = sefr_pkg::ST_WAIT;
      end
    endcase

    // good frame with payload: one result per stored byte
    if (st == sefr_pkg::ST_OK && len_q > 8'd0 && len_q <= MAX_LEN) begin
      for (int unsigned k = 0; k < len_q; k++) begin
        queue_result(sefr_pkg::ST_OK, pay_mem[k], k[2:0], (k + 1 == len_q));
      end
    end else begin
      queue_result(st, 8'h00, 3'd0, 1'b1);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_result();
    sefr_pkg::res_t e;
    if (due_results.size() == 0) begin
      $error("result transfer with nothing expected (status %0d)", status_i);
      fails++;
    end else begin
      e = due_results.pop_front();
      check_field("status", e.status, status_i);
      check_field("pkt_id", e.pkt_id, pkt_id_i);
      check_field("seq_num", e.seq_num, seq_num_i);
      check_field("payload_len", e.payload_len, payload_len_i);
      check_field("data_byte", e.data_byte, data_byte_i);
      check_field("byte_pos", e.byte_pos, byte_pos_i);
      check_field("last", e.last, last_i);
      check_field("ok_count", e.cnt[sefr_pkg::CNT_OK], ok_count_i);
      check_field("crc_fail_count", e.cnt[sefr_pkg::CNT_CRC_FAIL], crc_fail_count_i);
      check_field("format_fail_count", e.cnt[sefr_pkg::CNT_FMT_FAIL], format_fail_count_i);
      check_field("realign_count", e.cnt[sefr_pkg::CNT_RESYNC], realign_count_i);
    end
  endtask

  // result transfers are checked before the same edge's byte is parsed;
  // a byte's result can never leave in the cycle it arrives
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prs        = PRS_WAIT;
      fpos       = 0;
      id_q       = '0;
      seq_q      = '0;
      len_q      = '0;
      rx_crc_q   = '0;
      run_crc_q  = sefr_pkg::CRC_INIT;
      evt_cnt    = '0;
      start_mark = sefr_pkg::START_MARKER_RST;
      end_mark   = sefr_pkg::END_MARKER_RST;
      due_results.delete();
    end else begin
      if (pop_i && !empty_i) check_result();
      if (cfg_we_i) begin
        case (sefr_pkg::reg_idx_e'(cfg_addr_i))
          sefr_pkg::REG_START_MARKER: start_mark = cfg_wdata_i;
          sefr_pkg::REG_END_MARKER:   end_mark   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) parse_byte(rx_byte_i);
    end
    pending_o    = due_results.size();
    fail_count_o = fails;
  end

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN      = 8;
  localparam int unsigned PHASE_ITEMS  = 60;      // random bytes per marker setting
  localparam int unsigned LIMIT_CYCLES = 200000;  // far above the slowest legal run

  typedef enum int {FRM_GOOD, FRM_BAD_CRC, FRM_BAD_EOF, FRM_BAD_LEN} frame_kind_e;

  // DUT inputs start at known values; reset is held from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_addr_i  = '0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        push        = 1'b0;
  logic [7:0]  rx_byte_i   = '0;
  logic        pop         = 1'b0;

  logic        full;
  logic        empty;
  logic [2:0]  status_o;
  logic [15:0] pkt_id_o;
  logic [7:0]  seq_num_o;
  logic [3:0]  payload_len_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  byte_pos_o;
  logic        last_o;
  logic [31:0] ok_count_o;
  logic [31:0] crc_fail_count_o;
  logic [31:0] format_fail_count_o;
  logic [31:0] realign_count_o;

  int unsigned pending;
  int unsigned fail_count;

  // stimulus-side copy of the markers, used to build frames
  logic [7:0]  cur_start = sefr_pkg::START_MARKER_RST;
  logic [7:0]  cur_end   = sefr_pkg::END_MARKER_RST;
  logic [7:0]  pay_buf [MAX_LEN];
  int unsigned sent_items = 0;
  int unsigned cycles     = 0;
  bit          tx_steady  = 1'b0;   // sender runs back to back while set
  bit          rx_steady  = 1'b0;   // receiver pops back to back while set

  always #1 clk_i = ~clk_i;

  sof_eof_frame_receiver_crc16 #(
    .MAX_PAYLOAD(MAX_LEN)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte_i),
    .empty              (empty),
    .pop                (pop),
    .status_o           (status_o),
    .pkt_id_o           (pkt_id_o),
    .seq_num_o          (seq_num_o),
    .payload_len_o      (payload_len_o),
    .data_byte_o        (data_byte_o),
    .byte_pos_o         (byte_pos_o),
    .last_o             (last_o),
    .ok_count_o         (ok_count_o),
    .crc_fail_count_o   (crc_fail_count_o),
    .format_fail_count_o(format_fail_count_o),
    .realign_count_o    (realign_count_o)
  );

  sefr_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .push_i             (push),
    .full_i             (full),
    .rx_byte_i          (rx_byte_i),
    .empty_i            (empty),
    .pop_i              (pop),
    .status_i           (status_o),
    .pkt_id_i           (pkt_id_o),
    .seq_num_i          (seq_num_o),
    .payload_len_i      (payload_len_o),
    .data_byte_i        (data_byte_o),
    .byte_pos_i         (byte_pos_o),
    .last_i             (last_o),
    .ok_count_i         (ok_count_o),
    .crc_fail_count_i   (crc_fail_count_o),
    .format_fail_count_i(format_fail_count_o),
    .realign_count_i    (realign_count_o),
    .pending_o          (pending),
    .fail_count_o       (fail_count)
  );

  // One byte transfer. Called just after a falling edge. push is only lowered
  // when a gap is drawn, so back-to-back bytes keep it high without a glitch.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Sender holds off until every expected result has been transferred and the block is idle.
  task automatic drain_results();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Plain register write; only issued while idle. cfg_we_i drops again afterwards.
  task automatic write_reg(input sefr_pkg::reg_idx_e idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    if (idx == sefr_pkg::REG_START_MARKER) cur_start = v;
    else                                   cur_end   = v;
  endtask

  // Full frame: marker, id, seq, len, payload from pay_buf, CRC, end marker.
  // A bad length stops after the length byte; the block drops back to hunting.
  task automatic send_frame(input logic [15:0] id, input logic [7:0] seq,
                            input logic [7:0] len, input frame_kind_e kind);
    logic [15:0] crc;
    logic [15:0] crc_sent;
    logic [7:0]  tail;
    crc = sefr_pkg::CRC_INIT;
    send_byte(cur_start);
    send_byte(id[15:8]);
    crc = sefr_tb_pkg::crc16_ccitt_step(crc, id[15:8]);
    send_byte(id[7:0]);
    crc = sefr_tb_pkg::crc16_ccitt_step(crc, id[7:0]);
    send_byte(seq);
    crc = sefr_tb_pkg::crc16_ccitt_step(crc, seq);
    send_byte(len);
    crc = sefr_tb_pkg::crc16_ccitt_step(crc, len);
    if (kind == FRM_BAD_LEN) return;
    for (int k = 0; k < len; k++) begin
      send_byte(pay_buf[k]);
      crc = sefr_tb_pkg::crc16_ccitt_step(crc, pay_buf[k]);
    end
    crc_sent = (kind == FRM_BAD_CRC) ? crc ^ 16'($urandom_range(1, 16'hFFFF)) : crc;
    send_byte(crc_sent[15:8]);
    send_byte(crc_sent[7:0]);
    tail = (kind == FRM_BAD_EOF) ? cur_end ^ 8'($urandom_range(1, 255)) : cur_end;
    send_byte(tail);
  endtask

  // Result side: random stall before each pop, with stretches of none.
  initial begin : result_pop
    int unsigned stall;
    int unsigned popped;
    popped = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ((popped % 16) == 0 && $urandom_range(0, 3) == 0) rx_steady = ~rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      popped++;
      @(negedge clk_i);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  start_tab [5];
    logic [7:0]  end_tab   [5];
    int unsigned phase_end;
    int unsigned r;
    int unsigned n;
    logic [7:0]  len;

    // marker settings per phase: reset values, both extremes each way,
    // start equal to end, then random
    start_tab = '{8'hAA, 8'h00, 8'hFF, 8'h7E, 8'($urandom)};
    end_tab   = '{8'h55, 8'hFF, 8'h00, 8'h7E, 8'($urandom)};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part, reset markers ----
    send_byte(8'h00);                                  // noise while hunting
    send_frame(16'hFFFF, 8'hFF, 8'd0, FRM_GOOD);       // zero length, top id/seq
    send_frame(16'h0000, 8'h00, 8'd255, FRM_BAD_LEN);  // length far too large
    send_frame(16'h1234, 8'h01, 8'd0, FRM_BAD_CRC);    // CRC mismatch
    pay_buf[0] = 8'hFF;
    send_frame(16'h00FF, 8'h80, 8'd1, FRM_BAD_EOF);    // missing end marker

    // ---- random part, one phase per marker setting ----
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain_results();
        write_reg(sefr_pkg::REG_START_MARKER, start_tab[ph]);
        write_reg(sefr_pkg::REG_END_MARKER, end_tab[ph]);
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 9) == 0) tx_steady = ~tx_steady;
        // occasional full drain mid-phase
        if ($urandom_range(0, 24) == 0) drain_results();

        // payload: mostly random, sometimes marker values inside the data
        for (int k = 0; k < MAX_LEN; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            pay_buf[k] = $urandom_range(0, 1) ? cur_start : cur_end;
          end else begin
            pay_buf[k] = 8'($urandom);
          end
        end
        len = 8'($urandom_range(0, MAX_LEN));

        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_frame(16'($urandom), 8'($urandom), len, FRM_GOOD);
        end else if (r < 70) begin
          send_frame(16'($urandom), 8'($urandom), len, FRM_BAD_CRC);
        end else if (r < 78) begin
          send_frame(16'($urandom), 8'($urandom), len, FRM_BAD_EOF);
        end else if (r < 86) begin
          len = ($urandom_range(0, 3) == 0) ? 8'(MAX_LEN + 1)
                                            : 8'($urandom_range(MAX_LEN + 1, 255));
          send_frame(16'($urandom), 8'($urandom), len, FRM_BAD_LEN);
        end else if (r < 93) begin
          // line noise
          n = $urandom_range(1, 4);
          repeat (n) send_byte(8'($urandom));
        end else begin
          // truncated frame: the next frame's bytes land mid-parse
          send_byte(cur_start);
          n = $urandom_range(0, 6);
          repeat (n) send_byte(8'($urandom));
        end
      end
    end

    // ---- wind down ----
    drain_results();
    repeat (16) @(negedge clk_i);
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
